### hdl/escape_count_hue_colorizer_top_assert.svh
// assertion macros shared by the colouriser
`ifndef ESCAPE_COUNT_HUE_COLORIZER_TOP_ASSERT_SVH
`define ESCAPE_COUNT_HUE_COLORIZER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ECH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ECH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ech_pkg.sv
package ech_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int COUNT_BITS    = 16;
   localparam int ESCAPE_WIDTH  = 24;
   localparam int RGB_WIDTH     = 24;
   localparam int CHANNEL_BITS  = 8;
   localparam int FULL_WIDTH    = COUNT_BITS + FRACTION_BITS;
   localparam int REM_WIDTH     = FULL_WIDTH + CHANNEL_BITS;
   localparam int SECTOR_CELLS  = 3;
   localparam int SHADE_CELLS   = CHANNEL_BITS;

   localparam logic [COUNT_BITS-1:0]   LIMIT_RESET = COUNT_BITS'(256);
   localparam logic [CHANNEL_BITS-1:0] CHANNEL_MAX = '1;
   localparam logic [CHANNEL_BITS-1:0] CHANNEL_OFF = '0;

   typedef enum logic [SECTOR_CELLS-1:0] {
      SEC_RISE_GREEN = 3'd0,
      SEC_FALL_RED   = 3'd1,
      SEC_RISE_BLUE  = 3'd2,
      SEC_FALL_GREEN = 3'd3,
      SEC_RISE_RED   = 3'd4,
      SEC_FALL_BLUE  = 3'd5
   } ech_sector_type;

   typedef struct packed {
      logic                    black;
      ech_sector_type          sector;
      logic [REM_WIDTH-1:0]    rem;
      logic [REM_WIDTH-1:0]    div;
      logic [SHADE_CELLS-1:0]  quot;
   } ech_cell_data_type;

endpackage

### hdl/ech_req_if.sv
interface ech_req_if;
   import ech_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ESCAPE_WIDTH-1:0] escape_value;

   modport source (output valid, output escape_value, input ready);
   modport sink   (input valid, input escape_value, output ready);
endinterface

### hdl/ech_rsp_if.sv
interface ech_rsp_if;
   import ech_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [RGB_WIDTH-1:0] pixel_rgb;

   modport source (output valid, output pixel_rgb, input ready);
   modport sink   (input valid, input pixel_rgb, output ready);
endinterface

### hdl/ech_csr_if.sv
interface ech_csr_if;
   import ech_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] iteration_limit;

   modport source (output valid, output iteration_limit, input ready);
   modport sink   (input valid, input iteration_limit, output ready);
endinterface

### hdl/ech_div_cell.sv
module ech_div_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  ech_pkg::ech_cell_data_type up_data,
   output logic                       down_valid,
   input  logic                       down_ready,
   output ech_pkg::ech_cell_data_type down_data
);
   import ech_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   ech_cell_data_type data_ff;
   ech_cell_data_type data_in;
   logic              take;
   logic              fits;

   assign up_ready = !valid_ff || down_ready;
   assign take     = up_valid && up_ready;
   assign fits     = up_data.rem >= up_data.div;

   // one restoring step: subtract if it fits, halve the divisor
   always_comb begin
      data_in        = up_data;
      data_in.rem    = fits ? (up_data.rem - up_data.div) : up_data.rem;
      data_in.div    = up_data.div >> 1;
      data_in.quot   = {up_data.quot[SHADE_CELLS-2:0], fits};
      valid_in       = take ? 1'b1 : (down_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;
endmodule

### hdl/escape_count_hue_colorizer_top.sv
// hue palette for fractal escape values, one pixel per request
// path: sector cells, re-scale register, shade cells, then the response register
// throughput: one request per cycle while rsp ready holds, set by the row of one-bit divider cells
// a stalled response only holds the stages behind it, bubbles still collapse
// reset (synchronous): all stages empty, iteration limit back to 256
`include "escape_count_hue_colorizer_top_assert.svh"

module escape_count_hue_colorizer_top (
   input  logic        clock,
   input  logic        reset,
   ech_req_if.sink     req_chan,
   ech_rsp_if.source   rsp_chan,
   ech_csr_if.sink     csr_chan
);
   import ech_pkg::*;

   // configuration register; the user must write it only while the pipe is empty, the block does not enforce this
   logic [COUNT_BITS-1:0] limit_ff;
   logic [COUNT_BITS-1:0] limit_in;
   logic [FULL_WIDTH-1:0] full;

   assign csr_chan.ready = 1'b1;
   assign limit_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.iteration_limit : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // full scale D = limit with the fraction bits appended
   assign full = {limit_ff, FRACTION_BITS'(0)};

   // sector chain: t = 6*val divided by D, one quotient bit per cell
   logic              sec_valid [0:SECTOR_CELLS];
   logic              sec_ready [0:SECTOR_CELLS];
   ech_cell_data_type sec_data  [0:SECTOR_CELLS];
   logic [REM_WIDTH-1:0] val_wide;

   assign val_wide       = REM_WIDTH'(req_chan.escape_value);
   assign sec_valid[0]   = req_chan.valid;
   assign req_chan.ready = sec_ready[0];

   always_comb begin
      sec_data[0].black  = (full == '0) || (req_chan.escape_value >= full);
      sec_data[0].sector = SEC_RISE_GREEN;
      sec_data[0].rem    = (val_wide << 2) + (val_wide << 1);
      sec_data[0].div    = REM_WIDTH'(full) << (SECTOR_CELLS - 1);
      sec_data[0].quot   = '0;
   end

   for (genvar i = 0; i < SECTOR_CELLS; i++) begin : g_sector
      ech_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (sec_valid[i]),
         .up_ready   (sec_ready[i]),
         .up_data    (sec_data[i]),
         .down_valid (sec_valid[i+1]),
         .down_ready (sec_ready[i+1]),
         .down_data  (sec_data[i+1])
      );
   end

   // re-scale stage: numerator becomes 255*rem for the shade division
   logic              prep_valid_ff;
   logic              prep_valid_in;
   ech_cell_data_type prep_data_ff;
   ech_cell_data_type prep_data_in;
   logic              prep_take;

   logic              shd_valid [0:SHADE_CELLS];
   logic              shd_ready [0:SHADE_CELLS];
   ech_cell_data_type shd_data  [0:SHADE_CELLS];

   assign sec_ready[SECTOR_CELLS] = !prep_valid_ff || shd_ready[0];
   assign prep_take = sec_valid[SECTOR_CELLS] && sec_ready[SECTOR_CELLS];

   always_comb begin
      prep_data_in.black  = sec_data[SECTOR_CELLS].black;
      prep_data_in.sector = ech_sector_type'(sec_data[SECTOR_CELLS].quot[SECTOR_CELLS-1:0]);
      prep_data_in.rem    = (sec_data[SECTOR_CELLS].rem << CHANNEL_BITS)
                            - sec_data[SECTOR_CELLS].rem;
      prep_data_in.div    = REM_WIDTH'(full) << (SHADE_CELLS - 1);
      prep_data_in.quot   = '0;
      prep_valid_in       = prep_take ? 1'b1 : (shd_ready[0] ? 1'b0 : prep_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_take) begin
         prep_data_ff <= prep_data_in;
      end
   end

   // shade chain: x = floor(255*rem/D), eight quotient bits
   assign shd_valid[0] = prep_valid_ff;
   assign shd_data[0]  = prep_data_ff;

   for (genvar i = 0; i < SHADE_CELLS; i++) begin : g_shade
      ech_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (shd_valid[i]),
         .up_ready   (shd_ready[i]),
         .up_data    (shd_data[i]),
         .down_valid (shd_valid[i+1]),
         .down_ready (shd_ready[i+1]),
         .down_data  (shd_data[i+1])
      );
   end

   // colour assembly into the response register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [RGB_WIDTH-1:0]    rsp_rgb_ff;
   logic [RGB_WIDTH-1:0]    rsp_rgb_in;
   logic                    rsp_take;
   logic [CHANNEL_BITS-1:0] up_ramp;
   logic [CHANNEL_BITS-1:0] down_ramp;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;
   ech_cell_data_type       last;

   assign last     = shd_data[SHADE_CELLS];
   assign shd_ready[SHADE_CELLS] = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_take = shd_valid[SHADE_CELLS] && shd_ready[SHADE_CELLS];

   // falling ramp is 255 - ceil(255*rem/D)
   assign up_ramp   = last.quot;
   assign down_ramp = CHANNEL_MAX - up_ramp - CHANNEL_BITS'(last.rem != '0);

   always_comb begin
      red   = CHANNEL_OFF;
      green = CHANNEL_OFF;
      blue  = CHANNEL_OFF;
      case (last.sector)
         SEC_RISE_GREEN: begin
            red   = CHANNEL_MAX;
            green = up_ramp;
         end
         SEC_FALL_RED: begin
            red   = down_ramp;
            green = CHANNEL_MAX;
         end
         SEC_RISE_BLUE: begin
            green = CHANNEL_MAX;
            blue  = up_ramp;
         end
         SEC_FALL_GREEN: begin
            green = down_ramp;
            blue  = CHANNEL_MAX;
         end
         SEC_RISE_RED: begin
            red   = up_ramp;
            blue  = CHANNEL_MAX;
         end
         SEC_FALL_BLUE: begin
            red   = CHANNEL_MAX;
            blue  = down_ramp;
         end
         default: begin
            red   = CHANNEL_MAX;
            blue  = down_ramp;
         end
      endcase
      // escape values at or beyond the limit are painted black
      rsp_rgb_in   = last.black ? RGB_WIDTH'(0) : {red, green, blue};
      rsp_valid_in = rsp_take ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         rsp_rgb_ff <= rsp_rgb_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_rgb = rsp_rgb_ff;

   // checks
   `ECH_ASSERT_NOW(a_sector_range, clock, reset,
      sec_valid[SECTOR_CELLS] && !sec_data[SECTOR_CELLS].black,
      (sec_data[SECTOR_CELLS].quot[SECTOR_CELLS-1:0] <= SECTOR_CELLS'(SEC_FALL_BLUE))
         && (sec_data[SECTOR_CELLS].rem < REM_WIDTH'(full)),
      "sector division left an out of range quotient or remainder")
   `ECH_ASSERT_NOW(a_full_hue, clock, reset,
      rsp_valid_ff && (rsp_rgb_ff != '0),
      ((rsp_rgb_ff[23:16] == CHANNEL_MAX) || (rsp_rgb_ff[15:8] == CHANNEL_MAX)
         || (rsp_rgb_ff[7:0] == CHANNEL_MAX))
         && ((rsp_rgb_ff[23:16] == CHANNEL_OFF) || (rsp_rgb_ff[15:8] == CHANNEL_OFF)
         || (rsp_rgb_ff[7:0] == CHANNEL_OFF)),
      "coloured pixel lacks a full and an empty channel")
   `ECH_ASSERT_NEXT(a_entry_loaded, clock, reset,
      req_chan.valid && req_chan.ready,
      sec_valid[1],
      "accepted request did not enter the first cell")
endmodule

### dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ech_pkg::*;

   localparam int PERIOD        = 12;
   localparam int RESET_CYCLES  = 5;
   // scale for the settling wait before the verdict
   localparam int LATENCY       = 12;
   localparam int HOLD_CYCLES   = 60;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int PHASES        = 9;
   localparam int PRINT_CAP     = 40;

   // ------------------------------------------------------------------
   // expected colours, one per accepted request, in request order
   // ------------------------------------------------------------------
   class colour_scoreboard;
      logic [COUNT_BITS-1:0] limit;
      logic [RGB_WIDTH-1:0]  expected_pixels[$];
      int                    errors;

      function new();
         limit  = LIMIT_RESET;
         errors = 0;
      endfunction

      // hue palette: black at or above the limit, else six colour sectors
      function logic [RGB_WIDTH-1:0] paint(logic [ESCAPE_WIDTH-1:0] v);
         logic [63:0]             full;
         logic [63:0]             t;
         logic [63:0]             rem;
         logic [63:0]             up;
         logic [63:0]             down;
         ech_sector_type          sector;
         logic [CHANNEL_BITS-1:0] r;
         logic [CHANNEL_BITS-1:0] g;
         logic [CHANNEL_BITS-1:0] b;
         full = 64'(limit) << FRACTION_BITS;
         if (full == 64'd0 || 64'(v) >= full)
            return '0;
         t      = 64'(v) * 64'd6;
         sector = ech_sector_type'(SECTOR_CELLS'(t / full));
         rem    = t % full;
         up     = (rem * 64'd255) / full;
         down   = ((full - rem) * 64'd255) / full;
         case (sector)
            SEC_RISE_GREEN: {r, g, b} = {CHANNEL_MAX, up[7:0], CHANNEL_OFF};
            SEC_FALL_RED:   {r, g, b} = {down[7:0], CHANNEL_MAX, CHANNEL_OFF};
            SEC_RISE_BLUE:  {r, g, b} = {CHANNEL_OFF, CHANNEL_MAX, up[7:0]};
            SEC_FALL_GREEN: {r, g, b} = {CHANNEL_OFF, down[7:0], CHANNEL_MAX};
            SEC_RISE_RED:   {r, g, b} = {up[7:0], CHANNEL_OFF, CHANNEL_MAX};
            default:        {r, g, b} = {CHANNEL_MAX, CHANNEL_OFF, down[7:0]};
         endcase
         return {r, g, b};
      endfunction

      function void note_request(logic [ESCAPE_WIDTH-1:0] v);
         expected_pixels.push_back(paint(v));
      endfunction

      task report(string what);
         if (errors < PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, what);
         errors++;
      endtask

      task check_pixel(logic [RGB_WIDTH-1:0] got);
         logic [RGB_WIDTH-1:0] want;
         if (expected_pixels.size() == 0) begin
            report($sformatf("pixel_rgb %06h with no request outstanding", got));
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want)
            report($sformatf("pixel_rgb %06h, expected %06h", got, want));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   ech_req_if req_if ();
   ech_rsp_if rsp_if ();
   ech_csr_if csr_if ();

   colour_scoreboard colour_sb = new();

   // idling knobs, changed only between phases
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   logic hold_on = 1'b0;
   event start_hold;

   escape_count_hue_colorizer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #(PERIOD / 2) clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_CYCLES * PERIOD);
      $display("Simulation FAILED");
      $finish;
   end

   // long receiver hold-off, counted here so the sender keeps offering
   initial begin
      forever begin
         @(start_hold);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   // receiver: check every accepted pixel, then pick ready for the next edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            colour_sb.check_pixel(rsp_if.pixel_rgb);
         if (hold_on)
            rsp_if.ready <= 1'b0;
         else
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // one request; returns at the edge where it was accepted, valid left high
   task automatic send_pixel(input logic [ESCAPE_WIDTH-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.escape_value <= v;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      colour_sb.note_request(v);
   endtask

   // stop offering and wait for every outstanding colour
   task automatic drain_pixels();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (colour_sb.expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   // register write, only ever issued with the pipeline empty
   task automatic write_limit(input logic [COUNT_BITS-1:0] lim);
      csr_if.valid           <= 1'b1;
      csr_if.iteration_limit <= lim;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      colour_sb.limit = lim;
   endtask

   // mostly in-range values, some near sector edges and the limit, some raw
   function automatic logic [ESCAPE_WIDTH-1:0] pick_escape(logic [COUNT_BITS-1:0] lim);
      logic [31:0] full;
      logic [31:0] v;
      int unsigned pick;
      full = 32'(lim) << FRACTION_BITS;
      pick = $urandom_range(99);
      if (full == 32'd0 || pick < 10)
         return ESCAPE_WIDTH'($urandom);
      if (pick < 25) begin
         // k = 6 lands on the limit itself
         v = (32'($urandom_range(6)) * full) / 32'd6 + 32'($urandom_range(2)) - 32'd1;
         return ESCAPE_WIDTH'(v);
      end
      return ESCAPE_WIDTH'($urandom_range(full - 32'd1));
   endfunction

   initial begin
      logic [ESCAPE_WIDTH-1:0] directed_values[$];
      logic [COUNT_BITS-1:0]   phase_limit[PHASES];
      int                      phase_items[PHASES];
      int                      mode;

      // every port known from time zero
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.escape_value    = '0;
      rsp_if.ready           = 1'b0;
      csr_if.valid           = 1'b0;
      csr_if.iteration_limit = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset limit of 256 (full scale 65536)
      // zero, fraction bits, each sector edge, just below and at the limit,
      // far above the limit and the all-ones value
      directed_values = '{24'd0, 24'd1, 24'd255, 24'd256, 24'd10922, 24'd10923,
                          24'd21845, 24'd21846, 24'd32767, 24'd32768, 24'd43690,
                          24'd43691, 24'd54613, 24'd54614, 24'd65534, 24'd65535,
                          24'd65536, 24'd65537, 24'h800000, 24'h555555,
                          24'hAAAAAA, 24'hFFFFFF};
      foreach (directed_values[i])
         send_pixel(directed_values[i]);
      drain_pixels();

      // limits: smallest, largest, zero (all black), odd values, back to reset
      phase_limit = '{16'd1, 16'd65535, 16'd0, 16'd100,
                      COUNT_BITS'($urandom_range(65535, 1)), 16'd7,
                      COUNT_BITS'($urandom_range(65535, 1)), 16'd256, 16'd3000};
      phase_items = '{200, 250, 40, 200, 150, 150, 150, 200, 110};

      for (int p = 0; p < PHASES; p++) begin
         write_limit(phase_limit[p]);
         // cycle through no idling, sender idle, receiver stall, both
         mode = p % 4;
         send_idle_pct  = (mode == 1) ? 80 : (mode == 3) ? 36 : 0;
         recv_stall_pct <= (mode == 2) ? 80 : (mode == 3) ? 36 : 0;
         for (int n = 0; n < phase_items[p]; n++) begin
            // receiver holds off while requests keep coming, so the pipe backs up
            if (p == 0 && n == 50)
               -> start_hold;
            // sender pauses until the pipe has emptied
            if (p == 4 && n == phase_items[p] / 2)
               drain_pixels();
            send_pixel(pick_escape(phase_limit[p]));
         end
         drain_pixels();
      end

      // let any stray pixel show up before the verdict
      repeat (2 * LATENCY) @(posedge clock);

      if (colour_sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
